// ----- src/lbs_pkg.sv -----
// ----------------------------------------------------------------------------
// lbs_pkg
// Shared widths, types and register indexes of the line stepper.
// ----------------------------------------------------------------------------
package lbs_pkg;

	localparam int COORD_BITS = 16;
	localparam int ABS_W      = COORD_BITS + 1;
	localparam int ERR_W      = COORD_BITS + 3;
	localparam int E2_W       = COORD_BITS + 4;
	localparam int DIM_W      = 15;
	localparam int COLOR_W    = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [DIM_W-1:0]   WIDTH_RST  = DIM_W'(640);
	localparam logic [DIM_W-1:0]   HEIGHT_RST = DIM_W'(480);
	localparam logic [COLOR_W-1:0] COLOR_RST  = 32'hFF00_00FF;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR  = 2'd2;

	// item kinds
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_STEP = 1'b1;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [ABS_W-1:0]             absd_t;
	typedef logic signed [ERR_W-1:0]      err_t;

	// classified item as it sits in the queue
	typedef struct packed {
		logic   kind;
		coord_t x0;
		coord_t y0;
		coord_t x1;
		coord_t y1;
		absd_t  adx;
		absd_t  ady;
		logic   negx;
		logic   negy;
	} item_t;

	// queue to back end
	typedef struct packed {
		logic  valid;
		item_t item;
	} q_head_t;

endpackage

// ----- src/lbs_front.sv -----
// ----------------------------------------------------------------------------
// lbs_front
// Accepts input beats and classifies them: a load gets its deltas and step
// directions worked out before it enters the queue.
// ----------------------------------------------------------------------------
module lbs_front (
	input  logic            item_valid,
	input  logic            kind,
	input  lbs_pkg::coord_t start_x,
	input  lbs_pkg::coord_t start_y,
	input  lbs_pkg::coord_t end_x,
	input  lbs_pkg::coord_t end_y,
	input  logic            q_full,
	output logic            item_stall,
	output logic            push,
	output lbs_pkg::item_t  push_item
);
	import lbs_pkg::*;

	logic signed [ABS_W-1:0] dx;
	logic signed [ABS_W-1:0] dy;

	// signed deltas at one extra bit
	assign dx = ABS_W'(end_x) - ABS_W'(start_x);
	assign dy = ABS_W'(end_y) - ABS_W'(start_y);

	// hold input while the queue is full
	assign item_stall = q_full;
	assign push       = item_valid && !q_full;

	always_comb begin
		push_item.kind = kind;
		push_item.x0   = start_x;
		push_item.y0   = start_y;
		push_item.x1   = end_x;
		push_item.y1   = end_y;
		push_item.adx  = dx[ABS_W-1] ? absd_t'(-dx) : absd_t'(dx);
		push_item.ady  = dy[ABS_W-1] ? absd_t'(-dy) : absd_t'(dy);
		push_item.negx = !(start_x < end_x);
		push_item.negy = !(start_y < end_y);
	end

endmodule

// ----- src/lbs_queue.sv -----
// ----------------------------------------------------------------------------
// lbs_queue
// Two-entry queue between front and back end.
// ----------------------------------------------------------------------------
module lbs_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  lbs_pkg::item_t    push_item,
	input  logic              pop,
	output logic              full,
	output lbs_pkg::q_head_t  head
);
	import lbs_pkg::*;

	item_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	// store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	assign full       = (count_q == 2'd2);
	assign head.valid = (count_q != 2'd0);
	assign head.item  = mem_q[rd_ptr_q];

endmodule

// ----- src/lbs_back.sv -----
// ----------------------------------------------------------------------------
// lbs_back
// Line stepper proper: takes queued items, restarts on a load, emits one
// pixel per step into an output register and advances the error term.
// ----------------------------------------------------------------------------
module lbs_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lbs_pkg::q_head_t              head,
	output logic                          pop,
	input  logic [lbs_pkg::DIM_W-1:0]     scr_width,
	input  logic [lbs_pkg::DIM_W-1:0]     scr_height,
	input  logic [lbs_pkg::COLOR_W-1:0]   scr_color,
	output logic                          pixel_valid,
	input  logic                          pixel_stall,
	output lbs_pkg::coord_t               pixel_x,
	output lbs_pkg::coord_t               pixel_y,
	output logic                          visible,
	output logic [lbs_pkg::COLOR_W-1:0]   color,
	output logic                          last
);
	import lbs_pkg::*;

	coord_t cur_x_q, cur_y_q, tgt_x_q, tgt_y_q;
	absd_t  adx_q, ady_q;
	logic   negx_q, negy_q;
	err_t   err_q;
	logic   active_q;
	logic   out_valid_q;

	logic                   out_free;
	logic                   do_load;
	logic                   do_step;
	logic                   at_end;
	logic                   vis;
	logic signed [E2_W-1:0] e2;
	logic signed [E2_W-1:0] neg_ady;
	logic signed [E2_W-1:0] pos_adx;
	logic                   mv_x;
	logic                   mv_y;
	err_t                   err_nx;

	// take the next item when the output register can move
	assign out_free = !out_valid_q || !pixel_stall;
	assign pop      = head.valid && out_free;
	assign do_load  = pop && (head.item.kind == KIND_LOAD);
	assign do_step  = pop && (head.item.kind == KIND_STEP) && active_q;

	// classify the current pixel
	assign at_end = (cur_x_q == tgt_x_q) && (cur_y_q == tgt_y_q);
	assign vis    = !cur_x_q[COORD_BITS-1] && !cur_y_q[COORD_BITS-1]
		&& (32'(unsigned'(cur_x_q)) < 32'(scr_width))
		&& (32'(unsigned'(cur_y_q)) < 32'(scr_height));

	// decide both moves from the doubled error term
	assign e2      = $signed({err_q, 1'b0});
	assign pos_adx = $signed({{(E2_W-ABS_W){1'b0}}, adx_q});
	assign neg_ady = -$signed({{(E2_W-ABS_W){1'b0}}, ady_q});
	assign mv_x    = (e2 > neg_ady);
	assign mv_y    = (e2 < pos_adx);
	assign err_nx  = err_q - (mv_x ? err_t'(ady_q) : '0) + (mv_y ? err_t'(adx_q) : '0);

	// line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (do_load) begin
			active_q <= 1'b1;
		end else if (do_step && at_end) begin
			active_q <= 1'b0;
		end
	end

	// latch endpoints on load, advance on step
	always_ff @(posedge clk) begin
		if (do_load) begin
			cur_x_q <= head.item.x0;
			cur_y_q <= head.item.y0;
			tgt_x_q <= head.item.x1;
			tgt_y_q <= head.item.y1;
			adx_q   <= head.item.adx;
			ady_q   <= head.item.ady;
			negx_q  <= head.item.negx;
			negy_q  <= head.item.negy;
			err_q   <= err_t'(head.item.adx) - err_t'(head.item.ady);
		end else if (do_step && !at_end) begin
			err_q <= err_nx;
			if (mv_x) begin
				cur_x_q <= negx_q ? cur_x_q - coord_t'(1) : cur_x_q + coord_t'(1);
			end
			if (mv_y) begin
				cur_y_q <= negy_q ? cur_y_q - coord_t'(1) : cur_y_q + coord_t'(1);
			end
		end
	end

	// output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= do_step;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (do_step) begin
			pixel_x <= cur_x_q;
			pixel_y <= cur_y_q;
			visible <= vis;
			color   <= scr_color;
			last    <= at_end;
		end
	end

	assign pixel_valid = out_valid_q;

endmodule

// ----- src/bresenham_line_stepper_core.sv -----
// ----------------------------------------------------------------------------
// bresenham_line_stepper_core
// Bresenham line generator for all octants: load beats set the endpoints,
// step beats on a live line give a pixel each with clip flag, color, end mark.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------------
//  item     | item_valid / item_stall   | kind, start_x, start_y, end_x, end_y
//  pixel    | pixel_valid / pixel_stall | pixel_x, pixel_y, visible, color, last
//  config   | cfg_we                    | cfg_index, cfg_data
//
//  One item per clock sustained while the pixel channel is not stalled; a step's
//  pixel reaches the output through the queue slot, written at the accepting
//  edge, and then the output register. The pace is set by the back end's error
//  update, one add pair and compare per clock.
//  Reset: registers return to 640 x 480 and 0xFF0000FF, queue empties, no line.
//  A stalled pixel holds; the two-entry queue absorbs items, and item_stall
//  rises when it is full.
// ----------------------------------------------------------------------------
module bresenham_line_stepper_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [lbs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lbs_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             item_valid,
	output logic                             item_stall,
	input  logic                             kind,
	input  lbs_pkg::coord_t                  start_x,
	input  lbs_pkg::coord_t                  start_y,
	input  lbs_pkg::coord_t                  end_x,
	input  lbs_pkg::coord_t                  end_y,
	output logic                             pixel_valid,
	input  logic                             pixel_stall,
	output lbs_pkg::coord_t                  pixel_x,
	output lbs_pkg::coord_t                  pixel_y,
	output logic                             visible,
	output logic [lbs_pkg::COLOR_W-1:0]      color,
	output logic                             last
);
	import lbs_pkg::*;

	logic [DIM_W-1:0]   width_q;
	logic [DIM_W-1:0]   height_q;
	logic [COLOR_W-1:0] color_q;

	logic    push;
	item_t   push_item;
	logic    q_full;
	logic    pop;
	q_head_t head;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			color_q  <= COLOR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data[DIM_W-1:0];
				REG_HEIGHT: height_q <= cfg_data[DIM_W-1:0];
				REG_COLOR:  color_q  <= cfg_data[COLOR_W-1:0];
				default: ;
			endcase
		end
	end

	lbs_front u_front (
		.item_valid (item_valid),
		.kind       (kind),
		.start_x    (start_x),
		.start_y    (start_y),
		.end_x      (end_x),
		.end_y      (end_y),
		.q_full     (q_full),
		.item_stall (item_stall),
		.push       (push),
		.push_item  (push_item)
	);

	lbs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.full      (q_full),
		.head      (head)
	);

	lbs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.pop         (pop),
		.scr_width   (width_q),
		.scr_height  (height_q),
		.scr_color   (color_q),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.visible     (visible),
		.color       (color),
		.last        (last)
	);

endmodule

// ----- src/lbs_checker.sv -----
// ----------------------------------------------------------------------------
// lbs_checker
// Port-level checks of the line stepper, bound to the top level.
// ----------------------------------------------------------------------------
module lbs_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [lbs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lbs_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             item_stall,
	input  logic                             pixel_valid,
	input  logic                             pixel_stall,
	input  lbs_pkg::coord_t                  pixel_x,
	input  lbs_pkg::coord_t                  pixel_y,
	input  logic                             visible,
	input  logic                             last
);
	import lbs_pkg::*;

	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;

	// shadow the clip size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_WIDTH) begin
				width_q <= cfg_data[DIM_W-1:0];
			end
			if (cfg_index == REG_HEIGHT) begin
				height_q <= cfg_data[DIM_W-1:0];
			end
		end
	end

	// a stalled pixel beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && pixel_stall |=> pixel_valid && $stable(pixel_x)
			&& $stable(pixel_y) && $stable(last))
		else $error("stalled pixel beat changed");

	// visible pixels lie inside the screen
	a_vis: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && visible |-> !pixel_x[COORD_BITS-1] && !pixel_y[COORD_BITS-1]
			&& (32'(unsigned'(pixel_x)) < 32'(width_q))
			&& (32'(unsigned'(pixel_y)) < 32'(height_q)))
		else $error("visible pixel outside screen");

	// queue fills only behind a blocked output
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> $past(pixel_valid && pixel_stall))
		else $error("input stalled without output back-pressure");

	// zero-size screen clips everything
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && (width_q == '0 || height_q == '0) |-> !visible)
		else $error("pixel visible on empty screen");

endmodule

bind bresenham_line_stepper_core lbs_checker u_lbs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cfg_we      (cfg_we),
	.cfg_index   (cfg_index),
	.cfg_data    (cfg_data),
	.item_stall  (item_stall),
	.pixel_valid (pixel_valid),
	.pixel_stall (pixel_stall),
	.pixel_x     (pixel_x),
	.pixel_y     (pixel_y),
	.visible     (visible),
	.last        (last)
);

// ----- tb/sv/bresenham_line_stepper_core_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bresenham_line_stepper_core_test
// Self-checking bench for the line stepper. Load and step beats are queued by
// a stimulus process and fed through the item channel with random gaps; a
// predictor tracks the line state and screen registers and queues the pixel
// each accepted step should give. The monitor stalls the pixel channel at
// random, holds it off for long stretches, and checks every pixel in order.
// ----------------------------------------------------------------------------
module bresenham_line_stepper_core_test;
	import lbs_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LONG_HOLD      = 80;
	localparam int DRAIN          = 8;
	localparam int PHASE_ITEMS    = 300;

	// index past the register list, must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct {
		logic   kind;
		coord_t sx;
		coord_t sy;
		coord_t ex;
		coord_t ey;
	} stepper_beat_t;

	typedef struct {
		coord_t              x;
		coord_t              y;
		logic                vis;
		logic [COLOR_W-1:0]  rgba;
		logic                endpt;
	} pixel_exp_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  item_valid = 1'b0;
	logic                  item_stall;
	logic                  kind = KIND_LOAD;
	coord_t                start_x = '0;
	coord_t                start_y = '0;
	coord_t                end_x = '0;
	coord_t                end_y = '0;
	logic                  pixel_valid;
	logic                  pixel_stall = 1'b0;
	coord_t                pixel_x;
	coord_t                pixel_y;
	logic                  visible;
	logic [COLOR_W-1:0]    color;
	logic                  last;

	bresenham_line_stepper_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.kind        (kind),
		.start_x     (start_x),
		.start_y     (start_y),
		.end_x       (end_x),
		.end_y       (end_y),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.visible     (visible),
		.color       (color),
		.last        (last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// beats waiting for the driver, pixels waiting for the monitor
	stepper_beat_t pending[$];
	pixel_exp_t    pixel_exp_q[$];
	int            items_queued = 0;
	int            items_taken = 0;
	int            mismatches = 0;
	int            hold_requests = 0;

	// predicted line and register state
	coord_t              ln_cur_x = '0;
	coord_t              ln_cur_y = '0;
	coord_t              ln_tgt_x = '0;
	coord_t              ln_tgt_y = '0;
	logic                ln_neg_x = 1'b0;
	logic                ln_neg_y = 1'b0;
	absd_t               ln_adx = '0;
	absd_t               ln_ady = '0;
	err_t                ln_err = '0;
	logic                ln_active = 1'b0;
	logic [DIM_W-1:0]    scr_w = WIDTH_RST;
	logic [DIM_W-1:0]    scr_h = HEIGHT_RST;
	logic [COLOR_W-1:0]  rgba = COLOR_RST;

	// latch endpoints on a load, emit and advance on a step
	task automatic advance_stepper(stepper_beat_t b);
		int dx;
		int dy;
		int e2;
		pixel_exp_t px;
		if (b.kind == KIND_LOAD) begin
			dx = int'(b.ex) - int'(b.sx);
			dy = int'(b.ey) - int'(b.sy);
			ln_cur_x = b.sx;
			ln_cur_y = b.sy;
			ln_tgt_x = b.ex;
			ln_tgt_y = b.ey;
			ln_adx = absd_t'(dx < 0 ? -dx : dx);
			ln_ady = absd_t'(dy < 0 ? -dy : dy);
			ln_neg_x = !(b.sx < b.ex);
			ln_neg_y = !(b.sy < b.ey);
			ln_err = err_t'(int'(ln_adx) - int'(ln_ady));
			ln_active = 1'b1;
		end else if (ln_active) begin
			px.x = ln_cur_x;
			px.y = ln_cur_y;
			px.vis = !ln_cur_x[COORD_BITS-1] && ($unsigned(ln_cur_x) < {1'b0, scr_w}) &&
				!ln_cur_y[COORD_BITS-1] && ($unsigned(ln_cur_y) < {1'b0, scr_h});
			px.rgba = rgba;
			px.endpt = (ln_cur_x == ln_tgt_x) && (ln_cur_y == ln_tgt_y);
			pixel_exp_q.insert(pixel_exp_q.size(), px);
			if (px.endpt) begin
				ln_active = 1'b0;
			end else begin
				// both moves decided from the same doubled error
				e2 = 2 * int'(ln_err);
				if (e2 > -int'(ln_ady)) begin
					ln_err = err_t'(int'(ln_err) - int'(ln_ady));
					ln_cur_x = ln_neg_x ? ln_cur_x - 1'b1 : ln_cur_x + 1'b1;
				end
				if (e2 < int'(ln_adx)) begin
					ln_err = err_t'(int'(ln_err) + int'(ln_adx));
					ln_cur_y = ln_neg_y ? ln_cur_y - 1'b1 : ln_cur_y + 1'b1;
				end
			end
		end
	endtask

	// item driver: offer queued beats, hold while stalled, idle for random gaps between beats
	stepper_beat_t offered;
	int            gap_left = 0;
	bit            snd_calm = 1'b0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				advance_stepper(offered);
				items_taken++;
			end
			if (item_valid && item_stall) begin
				// hold the stalled beat
			end else if (gap_left != 0) begin
				gap_left--;
				item_valid <= 1'b0;
			end else if (pending.size() != 0) begin
				offered = pending.pop_front();
				kind <= offered.kind;
				start_x <= offered.sx;
				start_y <= offered.sy;
				end_x <= offered.ex;
				end_y <= offered.ey;
				item_valid <= 1'b1;
				if ($urandom_range(0, 29) == 0)
					snd_calm = !snd_calm;
				gap_left = snd_calm ? 0 : $urandom_range(0, 13);
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// pixel monitor: check each beat, then draw the next stall
	int stall_left = 0;
	int hold_left = 0;
	int holds_served = 0;
	bit rcv_calm = 1'b0;

	always @(posedge clk) begin
		pixel_exp_t px;
		if (arst_n) begin
			if (pixel_valid && !pixel_stall) begin
				if (pixel_exp_q.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected pixel x=%0d y=%0d", pixel_x, pixel_y);
					mismatches++;
				end else begin
					px = pixel_exp_q.pop_front();
					if (pixel_x !== px.x || pixel_y !== px.y || visible !== px.vis ||
					    color !== px.rgba || last !== px.endpt) begin
						if (mismatches < 10)
							$display({"pixel mismatch: exp x=%0d y=%0d vis=%0b color=%h last=%0b",
								" got x=%0d y=%0d vis=%0b color=%h last=%0b"},
								px.x, px.y, px.vis, px.rgba, px.endpt,
								pixel_x, pixel_y, visible, color, last);
						mismatches++;
					end
				end
				if ($urandom_range(0, 39) == 0)
					rcv_calm = !rcv_calm;
				stall_left = rcv_calm ? 0 : $urandom_range(0, 13);
			end
			if (holds_served != hold_requests) begin
				holds_served++;
				hold_left = LONG_HOLD;
			end
			if (hold_left != 0) begin
				hold_left--;
				pixel_stall <= 1'b1;
			end else if (stall_left != 0) begin
				stall_left--;
				pixel_stall <= 1'b1;
			end else begin
				pixel_stall <= 1'b0;
			end
		end
	end

	// watchdog: end the run when no handshake moves for too long
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (pixel_valid && !pixel_stall) || cfg_we) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("watchdog: no beat for %0d cycles", quiet_cycles);
					$display("bresenham_line_stepper_core_test: FAIL");
					$finish;
				end
			end
		end
	end

	task automatic queue_beat(logic k, coord_t a, coord_t b, coord_t c, coord_t d);
		stepper_beat_t nb;
		nb.kind = k;
		nb.sx = a;
		nb.sy = b;
		nb.ex = c;
		nb.ey = d;
		pending.insert(pending.size(), nb);
		items_queued++;
	endtask

	// step beats carry random endpoint fields, which the block ignores
	task automatic queue_steps(int n);
		for (int i = 0; i < n; i++)
			queue_beat(KIND_STEP, coord_t'($urandom), coord_t'($urandom),
				coord_t'($urandom), coord_t'($urandom));
	endtask

	function automatic coord_t clamp_coord(int v);
		if (v > 32767)
			return coord_t'(32767);
		if (v < -32768)
			return coord_t'(-32768);
		return coord_t'(v);
	endfunction

	// start point: anywhere, near the origin, near the screen edge, or near the extremes
	function automatic int pick_base(int span);
		coord_t r;
		case ($urandom_range(0, 3))
			0: begin
				r = coord_t'($urandom);
				return int'(r);
			end
			1: return int'($urandom_range(0, 40)) - 20;
			2: return span - 20 + int'($urandom_range(0, 40));
			default: return $urandom_range(0, 1) ? 32767 - int'($urandom_range(0, 30)) :
				-32768 + int'($urandom_range(0, 30));
		endcase
	endfunction

	function automatic int pick_delta();
		int mag;
		mag = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 200) : $urandom_range(0, 24);
		return $urandom_range(0, 1) ? -mag : mag;
	endfunction

	// one load followed by its steps: mostly whole lines, some cut short, some overrun
	task automatic queue_line(inout int counted);
		coord_t sx;
		coord_t sy;
		coord_t ex;
		coord_t ey;
		int adx;
		int ady;
		int len;
		int n;
		sx = clamp_coord(pick_base(int'(scr_w)));
		sy = clamp_coord(pick_base(int'(scr_h)));
		if ($urandom_range(0, 11) == 0) begin
			ex = coord_t'($urandom);
			ey = coord_t'($urandom);
		end else begin
			ex = clamp_coord(int'(sx) + pick_delta());
			ey = clamp_coord(int'(sy) + pick_delta());
		end
		queue_beat(KIND_LOAD, sx, sy, ex, ey);
		adx = int'(ex) - int'(sx);
		ady = int'(ey) - int'(sy);
		adx = adx < 0 ? -adx : adx;
		ady = ady < 0 ? -ady : ady;
		len = (adx > ady ? adx : ady) + 1;
		if (len > 400)
			n = $urandom_range(0, 12);
		else case ($urandom_range(0, 9))
			0: n = $urandom_range(0, len - 1);
			1: n = len + $urandom_range(1, 3);
			default: n = len;
		endcase
		queue_steps(n);
		counted += 1 + (n < len ? n : len);
	endtask

	task automatic wait_drained();
		while (items_taken != items_queued || pixel_exp_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic settle();
		wait_drained();
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_WIDTH:  scr_w = data[DIM_W-1:0];
			REG_HEIGHT: scr_h = data[DIM_W-1:0];
			REG_COLOR:  rgba = data[COLOR_W-1:0];
			default: ;
		endcase
	endtask

	// random lines; optionally hold the receiver off at the start, pause halfway
	task automatic random_phase(int target, bit squeeze);
		int counted;
		bit paused;
		counted = 0;
		paused = 1'b0;
		if (squeeze)
			hold_requests++;
		while (counted < target) begin
			queue_line(counted);
			while (pending.size() > 8)
				@(posedge clk);
			if (!paused && counted >= target / 2) begin
				paused = 1'b1;
				wait_drained();
			end
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// step with no line, then a single-pixel line and a step past its end
		queue_steps(1);
		queue_beat(KIND_LOAD, 16'sd5, 16'sd5, 16'sd5, 16'sd5);
		queue_steps(2);
		// shallow line to the right
		queue_beat(KIND_LOAD, 16'sd0, 16'sd0, 16'sd3, 16'sd1);
		queue_steps(4);
		// steep line up and left, restarted halfway
		queue_beat(KIND_LOAD, 16'sd2, 16'sd3, -16'sd1, -16'sd3);
		queue_steps(4);
		// corner to corner across the whole range
		queue_beat(KIND_LOAD, -16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768);
		queue_steps(2);
		// across the right screen edge on the bottom row
		queue_beat(KIND_LOAD, 16'sd638, 16'sd479, 16'sd641, 16'sd479);
		queue_steps(4);
		// single pixel at the extreme corner
		queue_beat(KIND_LOAD, 16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768);
		queue_steps(1);
		settle();
		random_phase(PHASE_ITEMS, 1'b1);

		settle();
		write_reg(REG_WIDTH, 32'd1);
		write_reg(REG_HEIGHT, 32'd1);
		write_reg(REG_COLOR, 32'h0000_0000);
		write_reg(REG_UNUSED, $urandom);
		random_phase(PHASE_ITEMS, 1'b0);

		settle();
		write_reg(REG_WIDTH, 32'd32767);
		write_reg(REG_HEIGHT, 32'd32767);
		write_reg(REG_COLOR, 32'hFFFF_FFFF);
		random_phase(PHASE_ITEMS, 1'b1);

		// zero width: nothing visible; upper data bits are dropped
		settle();
		write_reg(REG_WIDTH, 32'hFFFF_0000);
		write_reg(REG_HEIGHT, {17'($urandom_range(0, 131071)), 15'($urandom_range(1, 600))});
		write_reg(REG_COLOR, $urandom);
		random_phase(PHASE_ITEMS, 1'b0);

		settle();
		write_reg(REG_WIDTH, {17'($urandom_range(0, 131071)), 15'($urandom_range(1, 1000))});
		write_reg(REG_HEIGHT, {17'($urandom_range(0, 131071)), 15'($urandom_range(1, 1000))});
		write_reg(REG_COLOR, $urandom);
		random_phase(PHASE_ITEMS, 1'b1);

		settle();
		if (mismatches == 0)
			$display("bresenham_line_stepper_core_test: PASS");
		else
			$display("bresenham_line_stepper_core_test: FAIL");
		$finish;
	end

endmodule
